[src/mfcp_pkg.sv]
// metering frame checksum parser: shared types and constants
// item, command and result structs used by the front, queue and back modules
package mfcp_pkg;

  localparam int NUM_WORDS      = 6;
  localparam int WORD_W         = 24;
  localparam int BYTES_PER_WORD = 3;
  localparam int FIRST_WORD_POS = 2;
  localparam int UPDATE_POS     = 20;
  localparam int FACTOR_HI_POS  = 21;
  localparam int FACTOR_LO_POS  = 22;
  localparam int MIN_FRAME_LEN  = 24;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_IDLE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_GOOD  = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_BAD   = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic       is_idle;
    logic       is_short;
    logic [7:0] pos;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [23:0] voltage_coef;
    logic [23:0] voltage_period;
    logic [23:0] current_coef;
    logic [23:0] current_period;
    logic [23:0] power_coef;
    logic [23:0] power_period;
    logic [7:0]  update_flags;
    logic [15:0] pulse_count;
  } result_t;

endpackage

[src/mfcp_queue.sv]
// two-entry queue between stages of the frame parser
// generic over the item type; depends on nothing else
module mfcp_queue #(
  parameter type item_t = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_data,
  output logic  full,
  input  logic  pop,
  output item_t rd_data,
  output logic  empty
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[src/mfcp_front.sv]
// front end of the frame parser: accepts items, tracks frame position
// classifies each item into a command for the back end; uses mfcp_pkg
module mfcp_front #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mfcp_pkg::item_t item,
  output logic           full,
  output logic           cmd_push,
  output mfcp_pkg::cmd_t cmd,
  input  logic           cmd_full
);

  import mfcp_pkg::*;

  localparam logic [7:0] LAST_POS = 8'(BUFFER_DEPTH - 1);

  logic [7:0] byte_count;
  logic [7:0] byte_count_next;

  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full;

  always_comb begin
    cmd.is_idle  = (item.opcode == OP_IDLE);
    cmd.is_short = (byte_count < 8'(MIN_FRAME_LEN));
    cmd.pos      = byte_count;
    cmd.data     = item.byte_value;
  end

  always_comb begin
    byte_count_next = byte_count;
    if (cmd_push) begin
      if (item.opcode == OP_IDLE) begin
        byte_count_next = 8'd0;
      end else if (byte_count == LAST_POS) begin
        byte_count_next = 8'd0;
      end else begin
        byte_count_next = byte_count + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= 8'd0;
    end else begin
      byte_count <= byte_count_next;
    end
  end

endmodule

[src/mfcp_back.sv]
// back end of the frame parser: checksum, field capture and commit
// takes commands from the front queue, pushes results; uses mfcp_pkg
module mfcp_back (
  input  logic              clk,
  input  logic              rst,
  input  mfcp_pkg::cmd_t    cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  output logic              res_push,
  output mfcp_pkg::result_t res,
  input  logic              res_full
);

  import mfcp_pkg::*;

  logic [7:0]                         running_sum;
  logic [7:0]                         sum_before_last;
  logic [7:0]                         last_byte;
  logic [NUM_WORDS-1:0][WORD_W-1:0]   captured_words;
  logic [7:0]                         captured_update;
  logic [15:0]                        captured_factor;
  logic [NUM_WORDS-1:0][WORD_W-1:0]   committed_words;
  logic [7:0]                         committed_update;
  logic [15:0]                        committed_factor;

  logic                               byte_go;
  logic                               idle_go;
  logic                               commit;
  status_t                            status;
  logic [NUM_WORDS-1:0][WORD_W-1:0]   words_out;

  always_comb begin
    cmd_pop = !cmd_empty && (!cmd.is_idle || !res_full);
    byte_go = cmd_pop && !cmd.is_idle;
    idle_go = cmd_pop && cmd.is_idle;
    if (cmd.is_short) begin
      status = STATUS_SHORT;
    end else if (sum_before_last != last_byte) begin
      status = STATUS_BAD;
    end else begin
      status = STATUS_GOOD;
    end
    commit   = idle_go && (status == STATUS_GOOD);
    res_push = idle_go;
  end

  assign words_out = commit ? captured_words : committed_words;

  always_comb begin
    res.status         = status;
    res.voltage_coef   = words_out[0];
    res.voltage_period = words_out[1];
    res.current_coef   = words_out[2];
    res.current_period = words_out[3];
    res.power_coef     = words_out[4];
    res.power_period   = words_out[5];
    res.update_flags   = commit ? captured_update : committed_update;
    res.pulse_count    = commit ? captured_factor : committed_factor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum      <= 8'd0;
      sum_before_last  <= 8'd0;
      last_byte        <= 8'd0;
      captured_words   <= '0;
      captured_update  <= 8'd0;
      captured_factor  <= 16'd0;
      committed_words  <= '0;
      committed_update <= 8'd0;
      committed_factor <= 16'd0;
    end else begin
      if (byte_go) begin
        last_byte <= cmd.data;
        if (cmd.pos < 8'(FIRST_WORD_POS)) begin
          running_sum     <= 8'd0;
          sum_before_last <= 8'd0;
        end else begin
          sum_before_last <= running_sum;
          running_sum     <= running_sum + cmd.data;
        end
        for (int w = 0; w < NUM_WORDS; w++) begin
          for (int k = 0; k < BYTES_PER_WORD; k++) begin
            if (cmd.pos == 8'(FIRST_WORD_POS + BYTES_PER_WORD * w + k)) begin
              captured_words[w][(WORD_W - 1 - 8 * k) -: 8] <= cmd.data;
            end
          end
        end
        if (cmd.pos == 8'(UPDATE_POS)) begin
          captured_update <= cmd.data;
        end
        if (cmd.pos == 8'(FACTOR_HI_POS)) begin
          captured_factor[15:8] <= cmd.data;
        end
        if (cmd.pos == 8'(FACTOR_LO_POS)) begin
          captured_factor[7:0] <= cmd.data;
        end
      end
      if (commit) begin
        committed_words  <= captured_words;
        committed_update <= captured_update;
        committed_factor <= captured_factor;
      end
    end
  end

  a_result_only_on_idle: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (cmd_pop && cmd.is_idle))
    else $error("result pushed without an idle command");

  a_commit_copies_capture: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.status == STATUS_GOOD) |=>
      (committed_words == $past(captured_words) &&
       committed_factor == $past(captured_factor)))
    else $error("good frame did not commit captured fields");

  a_short_from_front: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.status == STATUS_SHORT) |-> cmd.is_short)
    else $error("short status without short frame");

  a_sum_cleared_at_start: assert property (@(posedge clk) disable iff (rst)
    (byte_go && cmd.pos < 8'(FIRST_WORD_POS)) |=>
      (running_sum == 8'd0 && sum_before_last == 8'd0))
    else $error("checksum not cleared at frame start");

endmodule

[src/metering_frame_checksum_parser.sv]
// top level of the metering frame checksum parser
// joins mfcp_front, two mfcp_queue instances and mfcp_back; uses mfcp_pkg
//
// The block takes one item per clock cycle while full is low, byte or line-idle
// event. A byte item yields no result; an idle item yields one result with the
// frame status and the committed measurement fields, visible on the result
// ports after the command queue, the back end and the result queue; the back end
// holds an idle item while the result queue is full. The front end keeps the
// frame position and feeds a two-entry command queue; the back end updates the
// checksum and captured fields per byte item and writes results into a two-entry
// result queue, so a stall on either side is absorbed until a queue fills. full
// reflects the command queue and empty the result queue.
module metering_frame_checksum_parser #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mfcp_pkg::item_t   item,
  output logic              full,
  input  logic              pop,
  output mfcp_pkg::result_t result,
  output logic              empty
);

  import mfcp_pkg::*;

  logic    cmd_push;
  logic    cmd_full;
  cmd_t    cmd_wr;
  cmd_t    cmd_rd;
  logic    cmd_empty;
  logic    cmd_pop;
  logic    res_push;
  logic    res_full;
  result_t res_wr;

  mfcp_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .cmd_push (cmd_push),
    .cmd      (cmd_wr),
    .cmd_full (cmd_full)
  );

  mfcp_queue #(
    .item_t(cmd_t)
  ) u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .wr_data (cmd_wr),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_rd),
    .empty   (cmd_empty)
  );

  mfcp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_rd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res_wr),
    .res_full  (res_full)
  );

  mfcp_queue #(
    .item_t(result_t)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .pop     (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule
